FILE: sv/thkr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thkr_pkg
// Shared types, constants and control structs of the tap/hold key resolver.
// ----------------------------------------------------------------------------
package thkr_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int RESULT_CAP  = 8;
    localparam int EV_IDX_W    = $clog2(RESULT_CAP);
    localparam int EV_CNT_W    = $clog2(RESULT_CAP + 1);

    localparam logic [7:0] TAP_RELEASE_RESET = 8'd3;

    localparam int FLAG_DLY  = 0;
    localparam int FLAG_OTH  = 1;
    localparam int FLAG_HELD = 2;
    localparam int FLAG_TAP  = 3;
    localparam int FLAG_GEN  = 4;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_TASK    = 2'd2,
        KIND_RESET   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [15:0] addr;
        logic [3:0]  kb;
        logic [15:0] deadline;
        logic [15:0] held_code;
        logic [15:0] tap_code;
        logic [4:0]  flags;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [15:0] code;
        logic        press;
        logic [3:0]  kb;
    } ev_t;

    typedef struct packed {
        logic accept;
        logic rd_scan;
        logic eval;
        logic move;
        logic out_next;
    } ctl_cmd_t;

    typedef struct packed {
        kind_t in_kind;
        logic  scan_end;
        logic  do_delete;
        logic  del_is_last;
        logic  out_last;
    } dp_status_t;

endpackage

FILE: sv/thkr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thkr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module thkr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/thkr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thkr_datapath
// Pending-key table, entry evaluation, event buffer and result fields.
// ----------------------------------------------------------------------------
module thkr_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic [1:0]          kind,
    input  logic [15:0]         now_ms,
    input  logic [15:0]         key_addr,
    input  logic [3:0]          kb_id,
    input  logic [15:0]         delay_ms,
    input  logic                delay_mode,
    input  logic                other_key_mode,
    input  logic [15:0]         hold_key_code,
    input  logic [15:0]         tap_key_code,
    input  logic                other_pressed,
    input  thkr_pkg::ctl_cmd_t  cmd,
    output thkr_pkg::dp_status_t status,
    output logic                has_event,
    output logic [15:0]         event_code,
    output logic                is_press,
    output logic [3:0]          event_kb,
    output logic                buffer_others,
    output logic                list_active
);
    import thkr_pkg::*;

    logic [CNT_W-1:0]    count_reg, count_next, count_m1;
    logic                buf_reg, buf_next;
    logic [7:0]          tap_rel_reg;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [EV_CNT_W-1:0] ev_cnt_reg, ev_cnt_next, ev_cnt_m1;
    logic [EV_IDX_W-1:0] out_idx_reg, out_idx_next;
    ev_t                 ev_buf_reg [RESULT_CAP];

    kind_t               kind_q_reg;
    logic [15:0]         now_q_reg;
    logic [15:0]         addr_q_reg;
    logic [3:0]          kb_q_reg;
    logic                oth_q_reg;

    logic                ram_wr_en, ram_rd_en;
    logic [IDX_W-1:0]    ram_wr_addr, ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_wr_data, ram_rd_data;

    entry_t              ent, ent_upd, press_ent;
    ev_t                 ev;
    logic                ev_valid, ev_push, wb, do_delete, clr_buf;
    logic                rel_match, ent_passed, no_gen;
    logic                hold_oth, hold_dly, tap_rel;
    logic [15:0]         dl_diff;

    thkr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign count_m1  = CNT_W'(count_reg - CNT_W'(1));
    assign ev_cnt_m1 = EV_CNT_W'(ev_cnt_reg - EV_CNT_W'(1));

    assign press_ent.addr      = key_addr;
    assign press_ent.kb        = kb_id;
    assign press_ent.deadline  = 16'(now_ms + delay_ms);
    assign press_ent.held_code = hold_key_code;
    assign press_ent.tap_code  = tap_key_code;
    assign press_ent.flags     = {3'b000, other_key_mode, delay_mode};

    // Evaluate the entry read at the scan index
    assign ent        = entry_t'(ram_rd_data);
    assign dl_diff    = 16'(now_q_reg - ent.deadline);
    assign ent_passed = ~dl_diff[15];
    assign no_gen     = ~ent.flags[FLAG_GEN];
    assign rel_match  = (ent.addr == addr_q_reg) && (ent.kb == kb_q_reg)
                        && (ent.flags[FLAG_DLY] || ent.flags[FLAG_OTH]);
    assign hold_oth   = no_gen && ent.flags[FLAG_OTH] && oth_q_reg && !ent.flags[FLAG_HELD];
    assign hold_dly   = no_gen && !oth_q_reg && ent.flags[FLAG_DLY] && ent_passed
                        && !ent.flags[FLAG_HELD] && !ent.flags[FLAG_TAP];
    assign tap_rel    = no_gen && !oth_q_reg && ent.flags[FLAG_TAP] && ent_passed;

    always_comb
    begin
        ent_upd   = ent;
        ev        = '0;
        ev_valid  = 1'b0;
        wb        = 1'b0;
        do_delete = 1'b0;
        clr_buf   = 1'b0;
        if (kind_q_reg == KIND_RELEASE)
        begin
            if (rel_match && ent.flags[FLAG_HELD])
            begin
                ev        = '{code: ent.held_code, press: 1'b0, kb: kb_q_reg};
                ev_valid  = 1'b1;
                do_delete = 1'b1;
            end
            else if (rel_match)
            begin
                ent_upd.flags[FLAG_TAP] = 1'b1;
                ent_upd.deadline        = 16'(now_q_reg + {8'd0, tap_rel_reg});
                wb       = 1'b1;
                ev       = '{code: ent.tap_code, press: 1'b1, kb: kb_q_reg};
                ev_valid = 1'b1;
            end
        end
        else
        begin
            if (hold_oth || hold_dly)
            begin
                ent_upd.flags[FLAG_HELD] = 1'b1;
                ent_upd.flags[FLAG_GEN]  = 1'b1;
                wb       = 1'b1;
                ev       = '{code: ent.held_code, press: 1'b1, kb: ent.kb};
                ev_valid = 1'b1;
                clr_buf  = hold_oth;
            end
            else if (tap_rel)
            begin
                ev        = '{code: ent.tap_code, press: 1'b0, kb: ent.kb};
                ev_valid  = 1'b1;
                do_delete = 1'b1;
            end
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        buf_next      = buf_reg;
        scan_idx_next = scan_idx_reg;
        ev_cnt_next   = ev_cnt_reg;
        out_idx_next  = out_idx_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = scan_idx_reg[IDX_W-1:0];
        ram_wr_data   = ENTRY_W'(ent_upd);
        ram_rd_en     = 1'b0;
        ram_rd_addr   = scan_idx_reg[IDX_W-1:0];
        ev_push       = 1'b0;
        if (cmd.accept)
        begin
            scan_idx_next = '0;
            ev_cnt_next   = '0;
            out_idx_next  = '0;
            unique case (kind_t'(kind))
                KIND_RESET:
                begin
                    count_next = '0;
                    buf_next   = 1'b0;
                end
                KIND_PRESS:
                begin
                    if (count_reg != CNT_W'(MAX_ENTRIES))
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_reg[IDX_W-1:0];
                        ram_wr_data = ENTRY_W'(press_ent);
                        count_next  = CNT_W'(count_reg + CNT_W'(1));
                        if (other_key_mode)
                        begin
                            buf_next = 1'b1;
                        end
                    end
                end
                KIND_RELEASE, KIND_TASK:
                begin
                end
            endcase
        end
        if (cmd.rd_scan)
        begin
            ram_rd_en = 1'b1;
        end
        if (cmd.eval)
        begin
            ram_wr_en = wb;
            if (ev_valid && (ev_cnt_reg < EV_CNT_W'(RESULT_CAP)))
            begin
                ev_push     = 1'b1;
                ev_cnt_next = EV_CNT_W'(ev_cnt_reg + EV_CNT_W'(1));
            end
            if (clr_buf)
            begin
                buf_next = 1'b0;
            end
            if (do_delete)
            begin
                if (scan_idx_reg == count_m1)
                begin
                    count_next = count_m1;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = count_m1[IDX_W-1:0];
                end
            end
            else
            begin
                scan_idx_next = CNT_W'(scan_idx_reg + CNT_W'(1));
            end
        end
        if (cmd.move)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data;
            count_next  = count_m1;
        end
        if (cmd.out_next)
        begin
            out_idx_next = EV_IDX_W'(out_idx_reg + EV_IDX_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            buf_reg      <= 1'b0;
            tap_rel_reg  <= TAP_RELEASE_RESET;
            scan_idx_reg <= '0;
            ev_cnt_reg   <= '0;
            out_idx_reg  <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            buf_reg      <= buf_next;
            scan_idx_reg <= scan_idx_next;
            ev_cnt_reg   <= ev_cnt_next;
            out_idx_reg  <= out_idx_next;
            if (cfg_wr_en)
            begin
                tap_rel_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_q_reg <= kind_t'(kind);
            now_q_reg  <= now_ms;
            addr_q_reg <= key_addr;
            kb_q_reg   <= kb_id;
            oth_q_reg  <= other_pressed;
        end
        if (ev_push)
        begin
            ev_buf_reg[ev_cnt_reg[EV_IDX_W-1:0]] <= ev;
        end
    end

    assign status.in_kind     = kind_t'(kind);
    assign status.scan_end    = (scan_idx_reg >= count_reg);
    assign status.do_delete   = do_delete;
    assign status.del_is_last = (scan_idx_reg == count_m1);
    assign status.out_last    = (ev_cnt_reg == '0)
                                || ({1'b0, out_idx_reg} == ev_cnt_m1);

    assign has_event     = (ev_cnt_reg != '0);
    assign event_code    = has_event ? ev_buf_reg[out_idx_reg].code  : 16'd0;
    assign is_press      = has_event ? ev_buf_reg[out_idx_reg].press : 1'b0;
    assign event_kb      = has_event ? ev_buf_reg[out_idx_reg].kb    : 4'd0;
    assign buffer_others = buf_reg;
    assign list_active   = (count_reg != '0);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_idx_reg <= count_reg)
        else $error("scan index beyond entry count");

    a_move_hole: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move |-> (scan_idx_reg < count_m1) && (count_reg != '0))
        else $error("move into a slot that is not a hole below the tail");

    a_eval_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval && do_delete && (scan_idx_reg == count_m1) |=> !list_active
            || (count_reg == $past(count_m1)))
        else $error("tail delete did not shrink the list");

endmodule

FILE: sv/thkr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thkr_ctrl
// Sequencer for accept, table scan, tail move and result delivery.
// ----------------------------------------------------------------------------
module thkr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  thkr_pkg::dp_status_t status,
    output thkr_pkg::ctl_cmd_t   cmd
);
    import thkr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_MOVE,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if ((status.in_kind == KIND_RELEASE) || (status.in_kind == KIND_TASK))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.do_delete && !status.del_is_last)
                begin
                    state_next = S_MOVE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_MOVE:
            begin
                cmd.move   = 1'b1;
                state_next = S_SCAN;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    cmd.out_next = 1'b1;
                    if (status.out_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    a_move_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move |-> $past(cmd.eval))
        else $error("tail move without a preceding delete");

    a_accept_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !out_valid && !cmd.eval && !cmd.move)
        else $error("transaction accepted while busy");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && status.out_last |=> in_ready)
        else $error("final result did not return to idle");

endmodule

FILE: sv/tap_hold_key_resolver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_hold_key_resolver_unit
// Tap/hold dual-role key resolver: pending-key table with event generation.
// ----------------------------------------------------------------------------
// Press and reset transactions: first result in the cycle after accept.
// Release and task transactions: each entry is read, then evaluated, plus a
//   compacting move after a delete below the tail, all on the single table
//   read port; then one result per cycle while out_ready is high, one
//   transaction at a time. Reset clears the list, the buffer flag and sets tap release to 3 ms; the
//   table needs no clearing pass.
module tap_hold_key_resolver_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [15:0] now_ms,
    input  logic [15:0] key_addr,
    input  logic [3:0]  kb_id,
    input  logic [15:0] delay_ms,
    input  logic        delay_mode,
    input  logic        other_key_mode,
    input  logic [15:0] hold_key_code,
    input  logic [15:0] tap_key_code,
    input  logic        other_pressed,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        has_event,
    output logic [15:0] event_code,
    output logic        is_press,
    output logic [3:0]  event_kb,
    output logic        last,
    output logic        buffer_others,
    output logic        list_active
);
    import thkr_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    thkr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    thkr_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .kind           (kind),
        .now_ms         (now_ms),
        .key_addr       (key_addr),
        .kb_id          (kb_id),
        .delay_ms       (delay_ms),
        .delay_mode     (delay_mode),
        .other_key_mode (other_key_mode),
        .hold_key_code  (hold_key_code),
        .tap_key_code   (tap_key_code),
        .other_pressed  (other_pressed),
        .cmd            (cmd),
        .status         (status),
        .has_event      (has_event),
        .event_code     (event_code),
        .is_press       (is_press),
        .event_kb       (event_kb),
        .buffer_others  (buffer_others),
        .list_active    (list_active)
    );

    assign last = status.out_last;

endmodule

FILE: tb/sv/thkr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thkr_checker
// Follows the transaction and result channels of the tap/hold key resolver.
// Keeps its own copy of the pending-key table and the tap release setting,
// predicts the key events of every accepted transaction and compares each
// accepted result with the oldest prediction, one field at a time.
// ----------------------------------------------------------------------------
module thkr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [15:0] now_ms,
    input  logic [15:0] key_addr,
    input  logic [3:0]  kb_id,
    input  logic [15:0] delay_ms,
    input  logic        delay_mode,
    input  logic        other_key_mode,
    input  logic [15:0] hold_key_code,
    input  logic [15:0] tap_key_code,
    input  logic        other_pressed,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        has_event,
    input  logic [15:0] event_code,
    input  logic        is_press,
    input  logic [3:0]  event_kb,
    input  logic        last,
    input  logic        buffer_others,
    input  logic        list_active,
    output int          fail_count,
    output int          outstanding,
    output int          results_checked
);
    import thkr_pkg::*;

    typedef struct packed {
        logic        has;
        logic [15:0] code;
        logic        press;
        logic [3:0]  kb;
        logic        last;
        logic        buf_o;
        logic        active;
    } key_result_t;

    entry_t      pend_tab [MAX_ENTRIES];
    int          pend_cnt;
    logic        buf_flag;
    logic [7:0]  tap_rel_ms;
    ev_t         item_events [$];
    key_result_t expected_results [$];
    int          err_total = 0;
    int          seen_total = 0;

    task automatic report_mismatch(input string msg);
        err_total++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      seen_total, name, got, want));
    endtask

    task automatic note_event(input logic [15:0] code, input logic press,
                              input logic [3:0] kb);
        ev_t ev;
        ev.code  = code;
        ev.press = press;
        ev.kb    = kb;
        if (item_events.size() < RESULT_CAP)
            item_events.push_back(ev);
    endtask

    task automatic drop_entry(input int idx);
        if (idx != pend_cnt - 1)
            pend_tab[idx] = pend_tab[pend_cnt - 1];
        pend_cnt--;
    endtask

    task automatic resolve_item(input kind_t k, input logic [15:0] t,
                                input logic [15:0] addr, input logic [3:0] kb,
                                input logic [15:0] dly, input logic ond,
                                input logic ono, input logic [15:0] hc,
                                input logic [15:0] tc, input logic oth);
        int          i;
        logic [4:0]  fl;
        logic [15:0] age;
        logic        due;
        key_result_t r;

        item_events.delete();
        case (k)
            KIND_RESET:
            begin
                pend_cnt = 0;
                buf_flag = 1'b0;
            end
            KIND_PRESS:
            begin
                if (pend_cnt < MAX_ENTRIES)
                begin
                    fl = '0;
                    fl[FLAG_DLY] = ond;
                    fl[FLAG_OTH] = ono;
                    pend_tab[pend_cnt].addr      = addr;
                    pend_tab[pend_cnt].kb        = kb;
                    pend_tab[pend_cnt].deadline  = t + dly;
                    pend_tab[pend_cnt].held_code = hc;
                    pend_tab[pend_cnt].tap_code  = tc;
                    pend_tab[pend_cnt].flags     = fl;
                    if (ono)
                        buf_flag = 1'b1;
                    pend_cnt++;
                end
            end
            KIND_RELEASE:
            begin
                i = 0;
                while (i < pend_cnt)
                begin
                    if (pend_tab[i].addr == addr && pend_tab[i].kb == kb &&
                        (pend_tab[i].flags[FLAG_DLY] || pend_tab[i].flags[FLAG_OTH]))
                    begin
                        if (pend_tab[i].flags[FLAG_HELD])
                        begin
                            note_event(pend_tab[i].held_code, 1'b0, kb);
                            drop_entry(i);
                            continue;
                        end
                        pend_tab[i].flags[FLAG_TAP] = 1'b1;
                        pend_tab[i].deadline = t + tap_rel_ms;
                        note_event(pend_tab[i].tap_code, 1'b1, kb);
                    end
                    i++;
                end
            end
            default:
            begin
                i = 0;
                while (i < pend_cnt)
                begin
                    fl  = pend_tab[i].flags;
                    age = t - pend_tab[i].deadline;
                    due = !age[15];
                    if (fl[FLAG_GEN])
                    begin
                        i++;
                        continue;
                    end
                    if (fl[FLAG_OTH] && oth && !fl[FLAG_HELD])
                    begin
                        fl[FLAG_HELD] = 1'b1;
                        fl[FLAG_GEN]  = 1'b1;
                        pend_tab[i].flags = fl;
                        note_event(pend_tab[i].held_code, 1'b1, pend_tab[i].kb);
                        buf_flag = 1'b0;
                    end
                    if (oth)
                    begin
                        i++;
                        continue;
                    end
                    if (fl[FLAG_DLY])
                    begin
                        if (!due)
                        begin
                            i++;
                            continue;
                        end
                        if (!fl[FLAG_HELD] && !fl[FLAG_TAP])
                        begin
                            fl[FLAG_HELD] = 1'b1;
                            fl[FLAG_GEN]  = 1'b1;
                            pend_tab[i].flags = fl;
                            note_event(pend_tab[i].held_code, 1'b1, pend_tab[i].kb);
                        end
                    end
                    if (fl[FLAG_TAP] && due)
                    begin
                        note_event(pend_tab[i].tap_code, 1'b0, pend_tab[i].kb);
                        drop_entry(i);
                        continue;
                    end
                    i++;
                end
            end
        endcase

        if (item_events.size() == 0)
        begin
            r        = '0;
            r.last   = 1'b1;
            r.buf_o  = buf_flag;
            r.active = (pend_cnt != 0);
            expected_results.push_back(r);
        end
        else
        begin
            for (i = 0; i < item_events.size(); i++)
            begin
                r.has    = 1'b1;
                r.code   = item_events[i].code;
                r.press  = item_events[i].press;
                r.kb     = item_events[i].kb;
                r.last   = (i == item_events.size() - 1);
                r.buf_o  = buf_flag;
                r.active = (pend_cnt != 0);
                expected_results.push_back(r);
            end
        end
    endtask

    task automatic check_result(input key_result_t got);
        key_result_t want;
        seen_total++;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with no prediction pending",
                                      seen_total));
            return;
        end
        want = expected_results.pop_front();
        compare_field("has_event", got.has, want.has);
        compare_field("event_code", got.code, want.code);
        compare_field("is_press", got.press, want.press);
        compare_field("event_kb", got.kb, want.kb);
        compare_field("last", got.last, want.last);
        compare_field("buffer_others", got.buf_o, want.buf_o);
        compare_field("list_active", got.active, want.active);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt   = 0;
            buf_flag   = 1'b0;
            tap_rel_ms = TAP_RELEASE_RESET;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                check_result('{has: has_event, code: event_code, press: is_press,
                               kb: event_kb, last: last, buf_o: buffer_others,
                               active: list_active});
            if (cfg_wr_en)
                tap_rel_ms = cfg_wr_data;
            if (in_valid && in_ready)
                resolve_item(kind_t'(kind), now_ms, key_addr, kb_id, delay_ms, delay_mode,
                             other_key_mode, hold_key_code, tap_key_code, other_pressed);
        end
        fail_count      <= err_total;
        outstanding     <= expected_results.size();
        results_checked <= seen_total;
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the tap/hold key resolver. A directed pass walks
// through taps, holds, wrapping deadlines and a full table; random key
// sequences from a small pool of keys then run under several tap release
// settings, with random gaps on both channels and long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
    import thkr_pkg::*;

    localparam int PHASE_ITEMS = 81;
    localparam int LONG_HOLD   = 200;
    localparam int POOL_KEYS   = 6;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] now_ms;
        logic [15:0] key_addr;
        logic [3:0]  kb_id;
        logic [15:0] delay_ms;
        logic        delay_mode;
        logic        other_key_mode;
        logic [15:0] hold_key_code;
        logic [15:0] tap_key_code;
        logic        other_pressed;
    } key_item_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [15:0] now_ms;
    logic [15:0] key_addr;
    logic [3:0]  kb_id;
    logic [15:0] delay_ms;
    logic        delay_mode;
    logic        other_key_mode;
    logic [15:0] hold_key_code;
    logic [15:0] tap_key_code;
    logic        other_pressed;
    logic        out_valid;
    logic        out_ready;
    logic        has_event;
    logic [15:0] event_code;
    logic        is_press;
    logic [3:0]  event_kb;
    logic        last;
    logic        buffer_others;
    logic        list_active;

    int          fail_count;
    int          outstanding;
    int          results_checked;

    logic [15:0] sim_ms;
    logic [15:0] pool_addr [POOL_KEYS];
    logic [3:0]  pool_kb [POOL_KEYS];
    int          items_sent = 0;
    logic        tx_steady;
    logic        rx_steady;
    int          hold_requests;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    tap_hold_key_resolver_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .now_ms         (now_ms),
        .key_addr       (key_addr),
        .kb_id          (kb_id),
        .delay_ms       (delay_ms),
        .delay_mode     (delay_mode),
        .other_key_mode (other_key_mode),
        .hold_key_code  (hold_key_code),
        .tap_key_code   (tap_key_code),
        .other_pressed  (other_pressed),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .has_event      (has_event),
        .event_code     (event_code),
        .is_press       (is_press),
        .event_kb       (event_kb),
        .last           (last),
        .buffer_others  (buffer_others),
        .list_active    (list_active)
    );

    thkr_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .now_ms          (now_ms),
        .key_addr        (key_addr),
        .kb_id           (kb_id),
        .delay_ms        (delay_ms),
        .delay_mode      (delay_mode),
        .other_key_mode  (other_key_mode),
        .hold_key_code   (hold_key_code),
        .tap_key_code    (tap_key_code),
        .other_pressed   (other_pressed),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .has_event       (has_event),
        .event_code      (event_code),
        .is_press        (is_press),
        .event_kb        (event_kb),
        .last            (last),
        .buffer_others   (buffer_others),
        .list_active     (list_active),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic key_item_t key_item(input kind_t k, input logic [15:0] t,
                                           input logic [15:0] a, input logic [3:0] b,
                                           input logic [15:0] d, input logic dl,
                                           input logic ot, input logic [15:0] h,
                                           input logic [15:0] tc, input logic op);
        key_item_t it;
        it.kind           = k;
        it.now_ms         = t;
        it.key_addr       = a;
        it.kb_id          = b;
        it.delay_ms       = d;
        it.delay_mode     = dl;
        it.other_key_mode = ot;
        it.hold_key_code  = h;
        it.tap_key_code   = tc;
        it.other_pressed  = op;
        return it;
    endfunction

    function automatic key_item_t random_item();
        key_item_t it;
        int        sel;
        int        k;
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, POOL_KEYS - 1);
        if ($urandom_range(0, 99) == 0)
            sim_ms = 16'($urandom);
        else
            sim_ms = sim_ms + 16'($urandom_range(0, 12));
        it.now_ms         = sim_ms;
        it.key_addr       = pool_addr[k];
        it.kb_id          = pool_kb[k];
        it.delay_ms       = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 40));
        it.delay_mode     = 1'($urandom);
        it.other_key_mode = 1'($urandom);
        it.hold_key_code  = 16'($urandom);
        it.tap_key_code   = 16'($urandom);
        it.other_pressed  = ($urandom_range(0, 3) == 0);
        if (sel < 3)
        begin
            it.kind     = kind_t'($urandom_range(0, 3));
            it.now_ms   = 16'($urandom);
            it.key_addr = 16'($urandom);
            it.kb_id    = 4'($urandom);
        end
        else if (sel < 28)
            it.kind = KIND_PRESS;
        else if (sel < 53)
            it.kind = KIND_RELEASE;
        else if (sel < 97)
            it.kind = KIND_TASK;
        else
            it.kind = KIND_RESET;
        return it;
    endfunction

    task automatic send(input key_item_t it);
        int g;
        in_valid       <= 1'b1;
        kind           <= it.kind;
        now_ms         <= it.now_ms;
        key_addr       <= it.key_addr;
        kb_id          <= it.kb_id;
        delay_ms       <= it.delay_ms;
        delay_mode     <= it.delay_mode;
        other_key_mode <= it.other_key_mode;
        hold_key_code  <= it.hold_key_code;
        tap_key_code   <= it.tap_key_code;
        other_pressed  <= it.other_pressed;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        g = tx_steady ? 0 : pick_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_tap_release(input logic [7:0] ms);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ms;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_directed();
        int k;
        send(key_item(KIND_TASK, 16'd0, 16'h1234, 4'd3, 16'd0, 1'b0, 1'b0,
                      16'h0000, 16'h0000, 1'b0));
        send(key_item(KIND_PRESS, 16'd10, 16'hFFFF, 4'hF, 16'hFFFF, 1'b1, 1'b1,
                      16'hFFFF, 16'h0000, 1'b0));
        send(key_item(KIND_PRESS, 16'd11, 16'h0000, 4'h0, 16'h0000, 1'b0, 1'b0,
                      16'h0000, 16'hFFFF, 1'b0));
        send(key_item(KIND_RELEASE, 16'd12, 16'h0000, 4'h0, 16'd0, 1'b0, 1'b0,
                      16'h0000, 16'h0000, 1'b0));
        send(key_item(KIND_TASK, 16'd13, 16'h0000, 4'h0, 16'd0, 1'b0, 1'b0,
                      16'h0000, 16'h0000, 1'b1));
        send(key_item(KIND_RELEASE, 16'd14, 16'hFFFF, 4'hF, 16'd0, 1'b0, 1'b0,
                      16'h0000, 16'h0000, 1'b0));
        send(key_item(KIND_PRESS, 16'd100, 16'h00A1, 4'h5, 16'd5, 1'b1, 1'b0,
                      16'h0A01, 16'h0A02, 1'b0));
        send(key_item(KIND_PRESS, 16'd100, 16'h00B2, 4'hA, 16'd5, 1'b1, 1'b0,
                      16'h0B01, 16'h0B02, 1'b0));
        send(key_item(KIND_RELEASE, 16'd102, 16'h00A1, 4'h5, 16'd0, 1'b0, 1'b0,
                      16'h0000, 16'h0000, 1'b0));
        send(key_item(KIND_TASK, 16'd104, 16'h0000, 4'h0, 16'd0, 1'b0, 1'b0,
                      16'h0000, 16'h0000, 1'b0));
        send(key_item(KIND_TASK, 16'd110, 16'h0000, 4'h0, 16'd0, 1'b0, 1'b0,
                      16'h0000, 16'h0000, 1'b0));
        send(key_item(KIND_RELEASE, 16'd111, 16'h00B2, 4'hA, 16'd0, 1'b0, 1'b0,
                      16'h0000, 16'h0000, 1'b0));
        send(key_item(KIND_PRESS, 16'hFFF0, 16'h7E57, 4'h9, 16'h0020, 1'b1, 1'b0,
                      16'h5A5A, 16'hA5A5, 1'b0));
        send(key_item(KIND_TASK, 16'hFFF8, 16'h0000, 4'h0, 16'd0, 1'b0, 1'b0,
                      16'h0000, 16'h0000, 1'b0));
        send(key_item(KIND_TASK, 16'h0012, 16'h0000, 4'h0, 16'd0, 1'b0, 1'b0,
                      16'h0000, 16'h0000, 1'b0));
        send(key_item(KIND_RELEASE, 16'h0013, 16'h7E57, 4'h9, 16'd0, 1'b0, 1'b0,
                      16'h0000, 16'h0000, 1'b0));
        // the entry without a mode is still in the table, so the last press is dropped
        for (k = 0; k < MAX_ENTRIES; k++)
            send(key_item(KIND_PRESS, 16'(200 + k), 16'(16'h0100 + k), 4'(k), 16'd1000,
                          1'(k % 2), 1'(1 - k % 2), 16'(16'h0C00 + k), 16'(16'h0D00 + k),
                          1'b0));
        send(key_item(KIND_RESET, 16'd300, 16'h0000, 4'h0, 16'd0, 1'b0, 1'b0,
                      16'h0000, 16'h0000, 1'b0));
    endtask

    initial
    begin : receiver
        int stall_left;
        int served;
        out_ready  = 1'b0;
        stall_left = 0;
        served     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != served)
            begin
                served     = hold_requests;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (rx_steady || $urandom_range(0, 99) < 60)
                out_ready <= 1'b1;
            else
            begin
                stall_left = pick_gap();
                out_ready <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] tap_steps [4];
        int         p;
        int         n;
        int         k;

        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        in_valid       = 1'b0;
        kind           = KIND_PRESS;
        now_ms         = '0;
        key_addr       = '0;
        kb_id          = '0;
        delay_ms       = '0;
        delay_mode     = 1'b0;
        other_key_mode = 1'b0;
        hold_key_code  = '0;
        tap_key_code   = '0;
        other_pressed  = 1'b0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        hold_requests  = 0;
        sim_ms         = 16'h0200;
        for (k = 0; k < POOL_KEYS; k++)
        begin
            pool_addr[k] = 16'($urandom);
            pool_kb[k]   = 4'($urandom);
        end
        pool_addr[1] = pool_addr[0];
        if (pool_kb[1] == pool_kb[0])
            pool_kb[1] = pool_kb[0] + 4'd1;

        tap_steps[0] = 8'd0;
        tap_steps[1] = 8'd255;
        tap_steps[2] = 8'($urandom_range(1, 254));
        tap_steps[3] = TAP_RELEASE_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_drain();

        for (p = 0; p < 4; p++)
        begin
            write_tap_release(tap_steps[p]);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 20 == 0)
                begin
                    tx_steady <= ($urandom_range(0, 3) == 0);
                    rx_steady <= ($urandom_range(0, 3) == 0);
                end
                if (n == 30 && p < 2)
                    hold_requests <= hold_requests + 1;
                if (n == 60)
                    wait_drain();
                send(random_item());
            end
            wait_drain();
        end

        repeat (40) @(posedge clk);
        $display("run covered %0d transactions and %0d results with %0d mismatches",
                 items_sent, results_checked, fail_count);
        $display("tap release swept 3, 0, 255, %0d and 3 ms; two long receiver hold-offs",
                 tap_steps[2]);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
